[rtl/dsabd_pkg.sv]
// ----------------------------------------------------------------------------
// dsabd_pkg
// Shared widths, register map and reset values for the detection score
// argmax and box decode block.
// ----------------------------------------------------------------------------
package dsabd_pkg;

  localparam int COORD_W   = 16;   // Q12.4 input geometry
  localparam int SCORE_W   = 16;   // Q0.16 scores
  localparam int CLASS_W   = 7;
  localparam int PAD_W     = 12;
  localparam int SCALE_W   = 24;   // Q8.16
  localparam int EDGE_W    = 21;   // signed Q16.4 output
  localparam int EDGE_IN_W = 19;   // signed edge in 1/32 pixel, padding removed

  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam int MAX_CLASSES_DEF = 128;

  localparam logic [SCORE_W-1:0] THRESHOLD_RST = 16'd32768;
  localparam logic [PAD_W-1:0]   PAD_RST       = 12'd0;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 24'd65536;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_PAD_X     = 2'd1,
    REG_PAD_Y     = 2'd2,
    REG_INV_SCALE = 2'd3
  } reg_idx_t;

endpackage

[rtl/dsabd_edge_map.sv]
// ----------------------------------------------------------------------------
// dsabd_edge_map
// Scales one padded-removed edge by the inverse scale, rounds half up to
// Q16.4 and saturates to the signed 21-bit range.
// ----------------------------------------------------------------------------
module dsabd_edge_map (
  input  logic signed [dsabd_pkg::EDGE_IN_W-1:0] edge_in,
  input  logic        [dsabd_pkg::SCALE_W-1:0]   inv_scale,
  output logic signed [dsabd_pkg::EDGE_W-1:0]    edge_out
);

  localparam int PROD_W = dsabd_pkg::EDGE_IN_W + dsabd_pkg::SCALE_W + 1;
  localparam int SHIFT  = 17;
  localparam int Q_W    = PROD_W - SHIFT;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (dsabd_pkg::EDGE_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(1 << (dsabd_pkg::EDGE_W - 1));

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [Q_W-1:0]    quot;

  always_comb begin
    prod    = edge_in * $signed({1'b0, inv_scale});
    rounded = prod + PROD_W'(1 << (SHIFT - 1));
    quot    = rounded[PROD_W-1:SHIFT];
    if (quot > Q_MAX) begin
      edge_out = Q_MAX[dsabd_pkg::EDGE_W-1:0];
    end else if (quot < Q_MIN) begin
      edge_out = Q_MIN[dsabd_pkg::EDGE_W-1:0];
    end else begin
      edge_out = quot[dsabd_pkg::EDGE_W-1:0];
    end
  end

endmodule

[rtl/detection_score_argmax_box_decode.sv]
// ----------------------------------------------------------------------------
// detection_score_argmax_box_decode
// Running argmax over per-class scores of a candidate box; on the last class
// a box at or above threshold is decoded to source-image corner coordinates.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in_      | in_valid / in_ready  | geometry, class_score, first/last flags
//  out_     | out_valid / out_ready| left/top/right/bottom edges, confidence, class_id
//  cfg      | APB psel/penable     | threshold, pad x/y, inverse scale
//
//  One request accepted per cycle while in_ready is high. Argmax state updates
//  at accept; a box request passes padding removal into a stage register,
//  then one multiply, round and saturate per edge into the output register.
//  in_ready drops only while the stage register is full and the output
//  register is held by out_ready low. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module detection_score_argmax_box_decode #(
  parameter int MAX_CLASSES = dsabd_pkg::MAX_CLASSES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dsabd_pkg::COORD_W-1:0]        in_center_x,
  input  logic [dsabd_pkg::COORD_W-1:0]        in_center_y,
  input  logic [dsabd_pkg::COORD_W-1:0]        in_box_width,
  input  logic [dsabd_pkg::COORD_W-1:0]        in_box_height,
  input  logic [dsabd_pkg::SCORE_W-1:0]        in_class_score,
  input  logic                                 in_first_class,
  input  logic                                 in_last_class,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dsabd_pkg::EDGE_W-1:0]  out_left_edge,
  output logic signed [dsabd_pkg::EDGE_W-1:0]  out_top_edge,
  output logic signed [dsabd_pkg::EDGE_W-1:0]  out_right_edge,
  output logic signed [dsabd_pkg::EDGE_W-1:0]  out_bottom_edge,
  output logic [dsabd_pkg::SCORE_W-1:0]        out_confidence,
  output logic [dsabd_pkg::CLASS_W-1:0]        out_class_id,

  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dsabd_pkg::APB_AW-1:0]         paddr,
  input  logic [dsabd_pkg::APB_DW-1:0]         pwdata,
  output logic [dsabd_pkg::APB_DW-1:0]         prdata,
  output logic                                 pready
);

  localparam int CW  = dsabd_pkg::CLASS_W;
  localparam int EIW = dsabd_pkg::EDGE_IN_W;
  localparam int CLASS_LIMIT = (MAX_CLASSES > (1 << CW)) ? (1 << CW) : MAX_CLASSES;
  localparam logic [CW-1:0] LAST_IDX = CW'(CLASS_LIMIT - 1);

  typedef struct packed {
    logic signed [EIW-1:0]             left;
    logic signed [EIW-1:0]             top;
    logic signed [EIW-1:0]             right;
    logic signed [EIW-1:0]             bottom;
    logic [dsabd_pkg::SCORE_W-1:0]     conf;
    logic [CW-1:0]                     cls;
  } stage_t;

  // configuration
  logic [dsabd_pkg::SCORE_W-1:0] thresh_r;
  logic [dsabd_pkg::PAD_W-1:0]   pad_x_r;
  logic [dsabd_pkg::PAD_W-1:0]   pad_y_r;
  logic [dsabd_pkg::SCALE_W-1:0] scale_r;
  dsabd_pkg::reg_idx_t           reg_sel;
  logic                          cfg_wr;

  // argmax state
  logic [dsabd_pkg::SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [CW-1:0]                 best_class_r, best_class_nxt;
  logic [CW-1:0]                 class_cnt_r, class_cnt_nxt;
  logic [dsabd_pkg::COORD_W-1:0] held_cx_r, held_cx_nxt;
  logic [dsabd_pkg::COORD_W-1:0] held_cy_r, held_cy_nxt;
  logic [dsabd_pkg::COORD_W-1:0] held_w_r, held_w_nxt;
  logic [dsabd_pkg::COORD_W-1:0] held_h_r, held_h_nxt;

  // pipeline
  logic   in_acc;
  logic   emit;
  logic   stg_valid_r;
  stage_t stg_r, stg_nxt;
  logic   out_load;
  logic   out_valid_r;
  logic signed [dsabd_pkg::EDGE_W-1:0] left_map, top_map, right_map, bottom_map;
  logic signed [dsabd_pkg::EDGE_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [dsabd_pkg::SCORE_W-1:0] conf_r;
  logic [CW-1:0]                 cls_r;

  logic signed [EIW-1:0] cx2, cy2, w_s, h_s, px_s, py_s;

  // config port
  assign pready  = 1'b1;
  assign reg_sel = dsabd_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_sel)
      dsabd_pkg::REG_THRESHOLD: prdata = dsabd_pkg::APB_DW'(thresh_r);
      dsabd_pkg::REG_PAD_X:     prdata = dsabd_pkg::APB_DW'(pad_x_r);
      dsabd_pkg::REG_PAD_Y:     prdata = dsabd_pkg::APB_DW'(pad_y_r);
      dsabd_pkg::REG_INV_SCALE: prdata = dsabd_pkg::APB_DW'(scale_r);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= dsabd_pkg::THRESHOLD_RST;
      pad_x_r  <= dsabd_pkg::PAD_RST;
      pad_y_r  <= dsabd_pkg::PAD_RST;
      scale_r  <= dsabd_pkg::SCALE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        dsabd_pkg::REG_THRESHOLD: thresh_r <= pwdata[dsabd_pkg::SCORE_W-1:0];
        dsabd_pkg::REG_PAD_X:     pad_x_r  <= pwdata[dsabd_pkg::PAD_W-1:0];
        dsabd_pkg::REG_PAD_Y:     pad_y_r  <= pwdata[dsabd_pkg::PAD_W-1:0];
        dsabd_pkg::REG_INV_SCALE: scale_r  <= pwdata[dsabd_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_load  = stg_valid_r & (~out_valid_r | out_ready);
  assign in_ready  = ~stg_valid_r | out_load;
  assign in_acc    = in_valid & in_ready;
  assign out_valid = out_valid_r;

  // argmax update
  always_comb begin
    best_score_nxt = best_score_r;
    best_class_nxt = best_class_r;
    class_cnt_nxt  = class_cnt_r;
    held_cx_nxt    = held_cx_r;
    held_cy_nxt    = held_cy_r;
    held_w_nxt     = held_w_r;
    held_h_nxt     = held_h_r;
    if (in_first_class) begin
      held_cx_nxt    = in_center_x;
      held_cy_nxt    = in_center_y;
      held_w_nxt     = in_box_width;
      held_h_nxt     = in_box_height;
      best_score_nxt = in_class_score;
      best_class_nxt = '0;
      class_cnt_nxt  = (LAST_IDX != '0) ? CW'(1) : '0;
    end else begin
      if (in_class_score > best_score_r) begin
        best_score_nxt = in_class_score;
        best_class_nxt = class_cnt_r;
      end
      if (class_cnt_r < LAST_IDX) begin
        class_cnt_nxt = class_cnt_r + CW'(1);
      end
    end
  end

  assign emit = in_last_class & (best_score_nxt >= thresh_r);

  // edges in 1/32 pixel with padding removed
  always_comb begin
    cx2  = $signed({2'b00, held_cx_nxt, 1'b0});
    cy2  = $signed({2'b00, held_cy_nxt, 1'b0});
    w_s  = $signed({3'b000, held_w_nxt});
    h_s  = $signed({3'b000, held_h_nxt});
    px_s = $signed({2'b00, pad_x_r, 5'b00000});
    py_s = $signed({2'b00, pad_y_r, 5'b00000});
    stg_nxt.left   = cx2 - w_s - px_s;
    stg_nxt.right  = cx2 + w_s - px_s;
    stg_nxt.top    = cy2 - h_s - py_s;
    stg_nxt.bottom = cy2 + h_s - py_s;
    stg_nxt.conf   = best_score_nxt;
    stg_nxt.cls    = best_class_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_score_r <= '0;
      best_class_r <= '0;
      class_cnt_r  <= '0;
      held_cx_r    <= '0;
      held_cy_r    <= '0;
      held_w_r     <= '0;
      held_h_r     <= '0;
      stg_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        best_score_r <= best_score_nxt;
        best_class_r <= best_class_nxt;
        class_cnt_r  <= class_cnt_nxt;
        held_cx_r    <= held_cx_nxt;
        held_cy_r    <= held_cy_nxt;
        held_w_r     <= held_w_nxt;
        held_h_r     <= held_h_nxt;
      end
      if (in_ready) begin
        stg_valid_r <= in_acc & emit;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc & emit) begin
      stg_r <= stg_nxt;
    end
    if (out_load) begin
      left_r   <= left_map;
      top_r    <= top_map;
      right_r  <= right_map;
      bottom_r <= bottom_map;
      conf_r   <= stg_r.conf;
      cls_r    <= stg_r.cls;
    end
  end

  dsabd_edge_map u_map_left (
    .edge_in  (stg_r.left),
    .inv_scale(scale_r),
    .edge_out (left_map)
  );

  dsabd_edge_map u_map_top (
    .edge_in  (stg_r.top),
    .inv_scale(scale_r),
    .edge_out (top_map)
  );

  dsabd_edge_map u_map_right (
    .edge_in  (stg_r.right),
    .inv_scale(scale_r),
    .edge_out (right_map)
  );

  dsabd_edge_map u_map_bottom (
    .edge_in  (stg_r.bottom),
    .inv_scale(scale_r),
    .edge_out (bottom_map)
  );

  assign out_left_edge   = left_r;
  assign out_top_edge    = top_r;
  assign out_right_edge  = right_r;
  assign out_bottom_edge = bottom_r;
  assign out_confidence  = conf_r;
  assign out_class_id    = cls_r;

endmodule
